[rtl/ratpg_pkg.sv]
// Shared types, constants and the gain microprogram of the relay autotuner.
`timescale 1ns / 1ps
`default_nettype none
package ratpg_pkg;

  localparam int GainFracBits = 16;
  localparam int ProdW = 112;
  localparam int FactW = 48;
  localparam int QuotW = 36;
  localparam int DivSteps = ProdW + GainFracBits + 1;
  localparam int CntW = $clog2(DivSteps + 1);
  localparam int NumSteps = 14;
  localparam int StepW = $clog2(NumSteps);
  localparam int TallyW = 16;

  localparam logic [FactW-1:0] PiNum = 48'd31415926;
  localparam logic [FactW-1:0] KpScale = 48'd48000000;
  localparam logic [FactW-1:0] KiScale = 48'd96000000000;
  localparam logic [FactW-1:0] KdScale = 48'd6000;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STAT_IDLE      = 3'd0,
    STAT_RUNNING   = 3'd1,
    STAT_TIMED_OUT = 3'd2,
    STAT_DONE_OK   = 3'd3,
    STAT_DONE_FAIL = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CFG_SETPOINT   = 3'd0,
    CFG_HYSTERESIS = 3'd1,
    CFG_AMPLITUDE  = 3'd2,
    CFG_TIMEOUT    = 3'd3,
    CFG_CYCLES     = 3'd4
  } cfg_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SETUP,
    FSM_MUL,
    FSM_DIV,
    FSM_DONE
  } fsm_t;

  typedef enum logic {KIND_MUL, KIND_DIV} kind_t;
  typedef enum logic [2:0] {A_D, A_DN, A_NUM, A_S, A_DEN} asel_t;
  typedef enum logic [2:0] {B_NS, B_NP, B_P, B_PI, B_KP, B_KI, B_KD} bsel_t;
  typedef enum logic [2:0] {D_DN, D_NUM, D_DEN, D_GP, D_GI, D_GD} dsel_t;

  typedef struct packed {
    kind_t kind;
    asel_t a_sel;
    bsel_t b_sel;
    dsel_t dest;
  } step_t;

  // kp = dn*48e6 / (S*PiNum), ki = dn*np*96e9 / (S*P*PiNum), kd = dn*P*6000 / (S*np*PiNum)
  function automatic step_t step_at(logic [StepW-1:0] idx);
    step_t s;
    s = '{KIND_MUL, A_D, B_NS, D_DN};
    unique case (idx)
      4'd0:  s = '{KIND_MUL, A_D,   B_NS, D_DN};
      4'd1:  s = '{KIND_MUL, A_DN,  B_KP, D_NUM};
      4'd2:  s = '{KIND_MUL, A_S,   B_PI, D_DEN};
      4'd3:  s = '{KIND_DIV, A_NUM, B_NS, D_GP};
      4'd4:  s = '{KIND_MUL, A_DN,  B_NP, D_NUM};
      4'd5:  s = '{KIND_MUL, A_NUM, B_KI, D_NUM};
      4'd6:  s = '{KIND_MUL, A_S,   B_P,  D_DEN};
      4'd7:  s = '{KIND_MUL, A_DEN, B_PI, D_DEN};
      4'd8:  s = '{KIND_DIV, A_NUM, B_NS, D_GI};
      4'd9:  s = '{KIND_MUL, A_DN,  B_P,  D_NUM};
      4'd10: s = '{KIND_MUL, A_NUM, B_KD, D_NUM};
      4'd11: s = '{KIND_MUL, A_S,   B_NP, D_DEN};
      4'd12: s = '{KIND_MUL, A_DEN, B_PI, D_DEN};
      4'd13: s = '{KIND_DIV, A_NUM, B_NS, D_GD};
      default: s = '{KIND_DIV, A_NUM, B_NS, D_GD};
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

[rtl/ratpg_if.sv]
// Valid/ready channel interfaces for input events and result transactions.
`timescale 1ns / 1ps
`default_nettype none
interface ratpg_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [31:0]       time_ms;
  logic signed [15:0] temperature;
  modport source (output valid, op, time_ms, temperature, input ready);
  modport sink (input valid, op, time_ms, temperature, output ready);
endinterface

interface ratpg_out_if;
  logic        valid;
  logic        ready;
  logic        relay_out;
  logic [2:0]  status;
  logic [31:0] gain_p;
  logic [31:0] gain_i;
  logic [31:0] gain_d;
  modport source (output valid, relay_out, status, gain_p, gain_i, gain_d, input ready);
  modport sink (input valid, relay_out, status, gain_p, gain_i, gain_d, output ready);
endinterface
`default_nettype wire

[rtl/relay_autotune_pid_gains_core.sv]
// Relay-feedback autotuner top level: relay control, peak tallies and gain sequencer.
// Start, stop and ordinary samples return their result through the output register.
// A completing sample runs 11 serial multiplies and 3 divisions, each after a setup state,
// on one shared shift-add/subtract unit; the input is not ready until the sequencer is
// idle again after the result has been registered.
// Throughput: one transaction per cycle when no gains are computed and the output is not stalled.
// Reset: synchronous, clears run state, configuration and output valid.
`timescale 1ns / 1ps
`default_nettype none
module relay_autotune_pid_gains_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  ratpg_in_if.sink         in_ch,
  ratpg_out_if.source      out_ch
);

  localparam int PW = ratpg_pkg::ProdW;
  localparam int FW = ratpg_pkg::FactW;
  localparam int QW = ratpg_pkg::QuotW;
  localparam int TW = ratpg_pkg::TallyW;

  logic signed [15:0] setpoint;
  logic [14:0]        hysteresis;
  logic [15:0]        relay_amplitude;
  logic [31:0]        timeout_limit;
  logic [7:0]         cycles_needed;

  logic               active, relay_state, seen_high, seen_low;
  logic [31:0]        start_time, last_high_time;
  logic signed [15:0] high_peak_temp, low_peak_temp;
  logic [47:0]        period_total_ms;
  logic [TW-1:0]      period_tally;
  logic [32:0]        swing_total;
  logic [TW-1:0]      swing_tally;

  logic               active_next, relay_next, seen_high_next, seen_low_next;
  logic [31:0]        start_time_next, last_high_next;
  logic signed [15:0] high_peak_next, low_peak_next;
  logic [47:0]        period_total_next;
  logic [TW-1:0]      period_tally_next;
  logic [32:0]        swing_total_next;
  logic [TW-1:0]      swing_tally_next;
  logic               res_relay, go_calc;
  ratpg_pkg::status_t res_status;

  ratpg_pkg::fsm_t    state, state_next;
  logic [ratpg_pkg::StepW-1:0] step;
  logic [ratpg_pkg::CntW-1:0]  cnt;
  ratpg_pkg::step_t   cur;
  logic [31:0]        dn;
  logic [PW-1:0]      num, den, ma, acc, rem, nsh;
  logic [FW-1:0]      mb;
  logic [QW-1:0]      quo;
  logic               sat;
  logic [31:0]        gp, gi, gd;

  logic               out_valid, o_relay;
  logic [2:0]         o_status;
  logic [31:0]        o_gp, o_gi, o_gd;

  logic               accept, slot_free;
  logic signed [17:0] upper, lower, temp_x;
  logic [31:0]        elapsed, per;
  logic signed [16:0] diff;
  logic [PW-1:0]      a_val, acc_step, rem_step;
  logic [FW-1:0]      b_val;
  logic [PW:0]        r2, r2_sub;
  logic               ge, sat_step;
  logic [QW-1:0]      q_step;
  logic [QW:0]        rnd;
  logic [31:0]        gain_val;

  assign slot_free   = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == ratpg_pkg::FSM_IDLE) && slot_free;
  assign accept      = in_ch.valid && in_ch.ready;

  assign out_ch.valid     = out_valid;
  assign out_ch.relay_out = o_relay;
  assign out_ch.status    = o_status;
  assign out_ch.gain_p    = o_gp;
  assign out_ch.gain_i    = o_gi;
  assign out_ch.gain_d    = o_gd;

  assign upper   = {{2{setpoint[15]}}, setpoint} + {3'b000, hysteresis};
  assign lower   = {{2{setpoint[15]}}, setpoint} - {3'b000, hysteresis};
  assign temp_x  = {{2{in_ch.temperature[15]}}, in_ch.temperature};
  assign elapsed = in_ch.time_ms - start_time;
  assign per     = in_ch.time_ms - last_high_time;
  assign diff    = {in_ch.temperature[15], in_ch.temperature}
                   - {low_peak_temp[15], low_peak_temp};

  always_comb begin
    active_next       = active;
    relay_next        = relay_state;
    seen_high_next    = seen_high;
    seen_low_next     = seen_low;
    start_time_next   = start_time;
    last_high_next    = last_high_time;
    high_peak_next    = high_peak_temp;
    low_peak_next     = low_peak_temp;
    period_total_next = period_total_ms;
    period_tally_next = period_tally;
    swing_total_next  = swing_total;
    swing_tally_next  = swing_tally;
    res_relay         = 1'b0;
    res_status        = ratpg_pkg::STAT_IDLE;
    go_calc           = 1'b0;
    unique case (ratpg_pkg::op_t'(in_ch.op))
      ratpg_pkg::OP_START: begin
        active_next       = 1'b1;
        relay_next        = 1'b1;
        start_time_next   = in_ch.time_ms;
        seen_high_next    = 1'b0;
        seen_low_next     = 1'b0;
        last_high_next    = '0;
        high_peak_next    = '0;
        low_peak_next     = '0;
        period_total_next = '0;
        period_tally_next = '0;
        swing_total_next  = '0;
        swing_tally_next  = '0;
        res_relay         = 1'b1;
        res_status        = ratpg_pkg::STAT_RUNNING;
      end
      ratpg_pkg::OP_STOP: active_next = 1'b0;
      ratpg_pkg::OP_NONE: begin
        if (active) begin
          res_relay  = relay_state;
          res_status = ratpg_pkg::STAT_RUNNING;
        end
      end
      ratpg_pkg::OP_SAMPLE: begin
        if (active) begin
          if (elapsed > timeout_limit) begin
            active_next = 1'b0;
            res_status  = ratpg_pkg::STAT_TIMED_OUT;
          end else begin
            if (relay_state && temp_x >= upper) begin
              relay_next     = 1'b0;
              high_peak_next = in_ch.temperature;
              if (seen_high && per != 32'd0 && period_tally != '1) begin
                period_total_next = period_total_ms + {16'd0, per};
                period_tally_next = period_tally + 1'b1;
              end
              last_high_next = in_ch.time_ms;
              seen_high_next = 1'b1;
              if (seen_low && diff > 17'sd0 && swing_tally != '1) begin
                swing_total_next = swing_total + {16'd0, diff};
                swing_tally_next = swing_tally + 1'b1;
              end
            end else if (!relay_state && temp_x <= lower) begin
              relay_next    = 1'b1;
              low_peak_next = in_ch.temperature;
              seen_low_next = 1'b1;
            end
            res_relay  = relay_next;
            res_status = ratpg_pkg::STAT_RUNNING;
            if (period_tally_next >= {8'd0, cycles_needed}
                && swing_tally_next >= {8'd0, cycles_needed}) begin
              active_next = 1'b0;
              if (period_tally_next == '0 || swing_tally_next == '0
                  || relay_amplitude == '0 || swing_total_next == '0
                  || period_total_next == '0) begin
                res_status = ratpg_pkg::STAT_DONE_FAIL;
              end else begin
                go_calc = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  // shared shift-add / shift-subtract unit
  assign cur = ratpg_pkg::step_at(step);

  always_comb begin
    unique case (cur.a_sel)
      ratpg_pkg::A_D:   a_val = {{(PW-16){1'b0}}, relay_amplitude};
      ratpg_pkg::A_DN:  a_val = {{(PW-32){1'b0}}, dn};
      ratpg_pkg::A_NUM: a_val = num;
      ratpg_pkg::A_S:   a_val = {{(PW-33){1'b0}}, swing_total};
      ratpg_pkg::A_DEN: a_val = den;
      default:          a_val = '0;
    endcase
    unique case (cur.b_sel)
      ratpg_pkg::B_NS: b_val = {{(FW-TW){1'b0}}, swing_tally};
      ratpg_pkg::B_NP: b_val = {{(FW-TW){1'b0}}, period_tally};
      ratpg_pkg::B_P:  b_val = period_total_ms;
      ratpg_pkg::B_PI: b_val = ratpg_pkg::PiNum;
      ratpg_pkg::B_KP: b_val = ratpg_pkg::KpScale;
      ratpg_pkg::B_KI: b_val = ratpg_pkg::KiScale;
      ratpg_pkg::B_KD: b_val = ratpg_pkg::KdScale;
      default:         b_val = '0;
    endcase
  end

  assign acc_step = {acc[PW-2:0], 1'b0} + (mb[FW-1] ? ma : '0);
  assign r2       = {rem, nsh[PW-1]};
  assign r2_sub   = r2 - {1'b0, den};
  assign ge       = r2 >= {1'b0, den};
  assign rem_step = ge ? r2_sub[PW-1:0] : r2[PW-1:0];
  assign q_step   = {quo[QW-2:0], ge};
  assign sat_step = sat || quo[QW-1];
  assign rnd      = ({1'b0, q_step} + 1'b1) >> 1;
  assign gain_val = (sat_step || (|rnd[QW:32])) ? '1 : rnd[31:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ratpg_pkg::FSM_IDLE:  if (accept && go_calc) state_next = ratpg_pkg::FSM_SETUP;
      ratpg_pkg::FSM_SETUP: state_next = (cur.kind == ratpg_pkg::KIND_MUL)
                                         ? ratpg_pkg::FSM_MUL : ratpg_pkg::FSM_DIV;
      ratpg_pkg::FSM_MUL:   if (cnt == ratpg_pkg::CntW'(FW - 1))
                              state_next = ratpg_pkg::FSM_SETUP;
      ratpg_pkg::FSM_DIV: begin
        if (cnt == ratpg_pkg::CntW'(ratpg_pkg::DivSteps - 1)) begin
          state_next = (step == ratpg_pkg::StepW'(ratpg_pkg::NumSteps - 1))
                       ? ratpg_pkg::FSM_DONE : ratpg_pkg::FSM_SETUP;
        end
      end
      ratpg_pkg::FSM_DONE:  if (slot_free) state_next = ratpg_pkg::FSM_IDLE;
      default:              state_next = ratpg_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ratpg_pkg::FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ratpg_pkg::FSM_IDLE: begin
        step <= '0;
      end
      ratpg_pkg::FSM_SETUP: begin
        cnt <= '0;
        ma  <= a_val;
        mb  <= b_val;
        acc <= '0;
        rem <= '0;
        nsh <= num;
        quo <= '0;
        sat <= 1'b0;
      end
      ratpg_pkg::FSM_MUL: begin
        cnt <= cnt + 1'b1;
        acc <= acc_step;
        mb  <= {mb[FW-2:0], 1'b0};
        if (cnt == ratpg_pkg::CntW'(FW - 1)) begin
          step <= step + 1'b1;
          unique case (cur.dest)
            ratpg_pkg::D_DN:  dn  <= acc_step[31:0];
            ratpg_pkg::D_NUM: num <= acc_step;
            ratpg_pkg::D_DEN: den <= acc_step;
            default: ;
          endcase
        end
      end
      ratpg_pkg::FSM_DIV: begin
        cnt <= cnt + 1'b1;
        rem <= rem_step;
        nsh <= {nsh[PW-2:0], 1'b0};
        quo <= q_step;
        sat <= sat_step;
        if (cnt == ratpg_pkg::CntW'(ratpg_pkg::DivSteps - 1)) begin
          step <= step + 1'b1;
          unique case (cur.dest)
            ratpg_pkg::D_GP: gp <= gain_val;
            ratpg_pkg::D_GI: gi <= gain_val;
            ratpg_pkg::D_GD: gd <= gain_val;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint        <= '0;
      hysteresis      <= '0;
      relay_amplitude <= '0;
      timeout_limit   <= '0;
      cycles_needed   <= '0;
      active          <= 1'b0;
      relay_state     <= 1'b0;
      seen_high       <= 1'b0;
      seen_low        <= 1'b0;
      start_time      <= '0;
      last_high_time  <= '0;
      high_peak_temp  <= '0;
      low_peak_temp   <= '0;
      period_total_ms <= '0;
      period_tally    <= '0;
      swing_total     <= '0;
      swing_tally     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ratpg_pkg::CFG_SETPOINT:   setpoint        <= cfg_data[15:0];
          ratpg_pkg::CFG_HYSTERESIS: hysteresis      <= cfg_data[14:0];
          ratpg_pkg::CFG_AMPLITUDE:  relay_amplitude <= cfg_data[15:0];
          ratpg_pkg::CFG_TIMEOUT:    timeout_limit   <= cfg_data;
          ratpg_pkg::CFG_CYCLES:     cycles_needed   <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (accept) begin
        active          <= active_next;
        relay_state     <= relay_next;
        seen_high       <= seen_high_next;
        seen_low        <= seen_low_next;
        start_time      <= start_time_next;
        last_high_time  <= last_high_next;
        high_peak_temp  <= high_peak_next;
        low_peak_temp   <= low_peak_next;
        period_total_ms <= period_total_next;
        period_tally    <= period_tally_next;
        swing_total     <= swing_total_next;
        swing_tally     <= swing_tally_next;
      end
      if (accept && !go_calc) begin
        out_valid <= 1'b1;
        o_relay   <= res_relay;
        o_status  <= res_status;
        o_gp      <= '0;
        o_gi      <= '0;
        o_gd      <= '0;
      end else if (state == ratpg_pkg::FSM_DONE && slot_free) begin
        out_valid <= 1'b1;
        o_relay   <= relay_state;
        o_status  <= ratpg_pkg::STAT_DONE_OK;
        o_gp      <= gp;
        o_gi      <= gi;
        o_gd      <= gd;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state != ratpg_pkg::FSM_IDLE |-> !in_ch.ready)
    else $error("input ready while gain sequencer busy");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    state == ratpg_pkg::FSM_DIV |-> rem < den)
    else $error("division remainder not below divisor");

  a_done_inactive: assert property (@(posedge clk) disable iff (rst)
    state == ratpg_pkg::FSM_DONE |-> !active)
    else $error("run still active after gain computation");

  a_calc_start: assert property (@(posedge clk) disable iff (rst)
    accept && go_calc |=> state == ratpg_pkg::FSM_SETUP && step == '0)
    else $error("gain sequencer did not start at first step");

endmodule
`default_nettype wire

[tb/sv/relay_autotune_pid_gains_core_tb.sv]
// Self-checking testbench for the relay autotuner: random relay runs, config sweeps, gain checks.
`timescale 1ns / 1ps
module relay_autotune_pid_gains_core_tb;
  import ratpg_pkg::*;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] tms;
    logic [15:0] temp;
  } event_t;

  typedef struct {
    logic        relay;
    logic [2:0]  stat;
    logic [31:0] gp;
    logic [31:0] gi;
    logic [31:0] gd;
  } tune_res_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  ratpg_in_if  in_ch ();
  ratpg_out_if out_ch ();

  relay_autotune_pid_gains_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // tuner model state and configuration
  int          m_sp;
  int          m_hyst;
  logic [15:0] m_amp;
  logic [31:0] m_tlim;
  logic [7:0]  m_ncyc;
  logic        m_act, m_relay, m_seen_hi, m_seen_lo;
  logic [31:0] m_t_start, m_t_hi;
  int          m_pk_hi, m_pk_lo;
  logic [47:0] m_per_sum;
  logic [32:0] m_sw_sum;
  logic [15:0] m_per_n, m_sw_n;

  event_t    pend_q[$];
  tune_res_t gains_q[$];
  int        errors;
  int        n_acc, n_res, n_gains, n_fail, n_tmo;
  int        in_gap, out_gap;
  int        idle_cnt;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [31:0] gain_ratio(logic [255:0] num, logic [255:0] den);
    logic [255:0] q;
    q = (num << (GainFracBits + 1)) / den;
    q = (q + 1) >> 1;
    return (q > 256'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
  endfunction

  function automatic tune_res_t tune_step(event_t ev);
    tune_res_t   r;
    int          upper, lower, t, diff;
    logic [31:0] per;
    logic [255:0] base, den, d, ns, np, pt;
    upper = m_sp + m_hyst;
    lower = m_sp - m_hyst;
    t = $signed(ev.temp);
    r = '{1'b0, STAT_IDLE, 32'd0, 32'd0, 32'd0};
    case (op_t'(ev.op))
      OP_START: begin
        m_act = 1'b1; m_relay = 1'b1; m_t_start = ev.tms;
        m_seen_hi = 1'b0; m_seen_lo = 1'b0; m_t_hi = '0;
        m_pk_hi = 0; m_pk_lo = 0;
        m_per_sum = '0; m_sw_sum = '0; m_per_n = '0; m_sw_n = '0;
        r.relay = 1'b1; r.stat = STAT_RUNNING;
        return r;
      end
      OP_STOP: begin
        m_act = 1'b0;
        return r;
      end
      OP_NONE: begin
        if (m_act) begin
          r.relay = m_relay; r.stat = STAT_RUNNING;
        end
        return r;
      end
      default: ;
    endcase
    if (!m_act) return r;
    if (ev.tms - m_t_start > m_tlim) begin
      m_act = 1'b0;
      r.stat = STAT_TIMED_OUT;
      return r;
    end
    if (m_relay && t >= upper) begin
      m_relay = 1'b0;
      m_pk_hi = t;
      if (m_seen_hi) begin
        per = ev.tms - m_t_hi;
        if (per != 0 && m_per_n != 16'hFFFF) begin
          m_per_sum += per;
          m_per_n++;
        end
      end
      m_t_hi = ev.tms;
      m_seen_hi = 1'b1;
      if (m_seen_lo) begin
        diff = m_pk_hi - m_pk_lo;
        if (diff > 0 && m_sw_n != 16'hFFFF) begin
          m_sw_sum += diff;
          m_sw_n++;
        end
      end
    end else if (!m_relay && t <= lower) begin
      m_relay = 1'b1;
      m_pk_lo = t;
      m_seen_lo = 1'b1;
    end
    r.relay = m_relay;
    r.stat = STAT_RUNNING;
    if (m_per_n >= m_ncyc && m_sw_n >= m_ncyc) begin
      m_act = 1'b0;
      r.stat = STAT_DONE_FAIL;
      if (m_per_n != 0 && m_sw_n != 0 && m_amp != 0 && m_sw_sum != 0 && m_per_sum != 0) begin
        d = m_amp; ns = m_sw_n; np = m_per_n; pt = m_per_sum;
        base = d * ns * 256'd10000000;
        den = 256'd31415926 * m_sw_sum;
        r.gp = gain_ratio(base * 48, den * 10);
        r.gi = gain_ratio(base * 96000 * np, den * 10 * pt);
        r.gd = gain_ratio(base * 600 * pt, den * 1000000 * np);
        r.stat = STAT_DONE_OK;
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 30) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(0, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
    errors++;
    $display("MISMATCH %s: expected %0h got %0h at %0t", what, exp_v, got_v, $realtime);
  endtask

  // driver
  always @(posedge clk) begin
    event_t ev;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        ev = '{in_ch.op, in_ch.time_ms, in_ch.temperature};
        gains_q.push_back(tune_step(ev));
        n_acc++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          ev = pend_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.op <= ev.op;
          in_ch.time_ms <= ev.tms;
          in_ch.temperature <= ev.temp;
          in_gap <= pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    tune_res_t e;
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_res++;
        if (gains_q.size() == 0) begin
          report("unexpected transaction", 32'd0, {29'd0, out_ch.status});
        end else begin
          e = gains_q.pop_front();
          if (e.stat == STAT_DONE_OK) n_gains++;
          if (e.stat == STAT_DONE_FAIL) n_fail++;
          if (e.stat == STAT_TIMED_OUT) n_tmo++;
          if (out_ch.relay_out !== e.relay) report("relay_out", e.relay, out_ch.relay_out);
          if (out_ch.status !== e.stat) report("status", e.stat, out_ch.status);
          if (out_ch.gain_p !== e.gp) report("gain_p", e.gp, out_ch.gain_p);
          if (out_ch.gain_i !== e.gi) report("gain_i", e.gi, out_ch.gain_i);
          if (out_ch.gain_d !== e.gd) report("gain_d", e.gd, out_ch.gain_d);
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        out_gap <= pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= 20000) begin
      $display("timeout: no transaction for %0d cycles", idle_cnt);
      $display("relay_autotune_pid_gains_core_tb: errors");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  task automatic push_ev(op_t op, logic [31:0] tms, int temp);
    event_t ev;
    ev.op = op; ev.tms = tms; ev.temp = temp[15:0];
    pend_q.push_back(ev);
  endtask

  task automatic wait_idle();
    @(posedge clk);
    #1;
    while (pend_q.size() > 0 || in_ch.valid || gains_q.size() > 0) begin
      @(posedge clk);
      #1;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      CFG_SETPOINT:   m_sp = $signed(v[15:0]);
      CFG_HYSTERESIS: m_hyst = v[14:0];
      CFG_AMPLITUDE:  m_amp = v[15:0];
      CFG_TIMEOUT:    m_tlim = v;
      CFG_CYCLES:     m_ncyc = v[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_cfg(int sp, int hy, int amp, logic [31:0] tl, int nc);
    wait_idle();
    cfg_write(CFG_SETPOINT, sp);
    cfg_write(CFG_HYSTERESIS, hy);
    cfg_write(CFG_AMPLITUDE, amp);
    cfg_write(CFG_TIMEOUT, tl);
    cfg_write(CFG_CYCLES, nc);
  endtask

  function automatic int clamp16(int v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  // oscillating run with random content, sprinkled with noise and stray ops
  task automatic gen_run(int n, int max_step);
    logic [31:0] t;
    bit          hi;
    int          temp, k;
    t = $urandom;
    hi = 1'b1;
    push_ev(OP_START, t, $urandom);
    for (int i = 0; i < n; i++) begin
      t += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, max_step);
      k = $urandom_range(0, 99);
      if (k < 4) begin
        push_ev(op_t'($urandom_range(1, 3)), t, $urandom);
        continue;
      end
      if (k < 12) temp = $signed(16'($urandom));
      else if (k < 30) temp = m_sp + $urandom_range(0, 2 * m_hyst + 1) - m_hyst;
      else begin
        temp = hi ? m_sp + m_hyst + $urandom_range(0, 300)
                  : m_sp - m_hyst - $urandom_range(0, 300);
        hi = !hi;
      end
      push_ev(OP_SAMPLE, t, clamp16(temp));
    end
    if ($urandom_range(0, 1)) push_ev(OP_STOP, t, $urandom);
  endtask

  initial begin
    int left;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = CFG_SETPOINT; cfg_data = '0;
    in_ch.valid = 1'b0; in_ch.op = OP_SAMPLE; in_ch.time_ms = '0; in_ch.temperature = '0;
    out_ch.ready = 1'b0;
    errors = 0; n_acc = 0; n_res = 0; n_gains = 0; n_fail = 0; n_tmo = 0;
    m_sp = 0; m_hyst = 0; m_amp = 0; m_tlim = 0; m_ncyc = 0;
    m_act = 0; m_relay = 0; m_seen_hi = 0; m_seen_lo = 0;
    m_t_start = 0; m_t_hi = 0; m_pk_hi = 0; m_pk_lo = 0;
    m_per_sum = 0; m_sw_sum = 0; m_per_n = 0; m_sw_n = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: reset config, idle ops, zero-cycle completion, timeout, extremes
    push_ev(OP_SAMPLE, 32'd0, -32768);
    push_ev(OP_NONE, 32'd5, 0);
    push_ev(OP_STOP, 32'hFFFFFFFF, 32767);
    push_ev(OP_START, 32'hFFFFFFFF, 0);
    push_ev(OP_NONE, 32'd0, 0);
    push_ev(OP_SAMPLE, 32'hFFFFFFFF, 32767);
    push_ev(OP_START, 32'd100, 0);
    push_ev(OP_SAMPLE, 32'd101, 0);
    set_cfg(0, 100, 65535, 50, 1);
    push_ev(OP_START, 32'hFFFFFFF0, 0);
    push_ev(OP_SAMPLE, 32'h00000030, 300);
    push_ev(OP_SAMPLE, 32'h00000040, 0);
    push_ev(OP_START, 32'd0, 0);
    push_ev(OP_SAMPLE, 32'd10, 32767);
    push_ev(OP_SAMPLE, 32'd15, -32768);
    push_ev(OP_NONE, 32'd16, 0);
    push_ev(OP_SAMPLE, 32'd20, 200);
    push_ev(OP_SAMPLE, 32'd20, -200);
    push_ev(OP_SAMPLE, 32'd40, 200);
    push_ev(OP_SAMPLE, 32'd45, -300);
    push_ev(OP_SAMPLE, 32'd50, 32767);
    push_ev(OP_STOP, 32'd60, 0);
    set_cfg(-32768, 0, 1, 32'hFFFFFFFF, 1);
    push_ev(OP_START, 32'd0, 0);
    push_ev(OP_SAMPLE, 32'd1, -32768);
    push_ev(OP_SAMPLE, 32'd2, -32768);
    push_ev(OP_SAMPLE, 32'd3, -32768);
    push_ev(OP_SAMPLE, 32'd4, -32768);

    // random phases across config settings
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:  set_cfg(32767, 32767, 65535, 32'hFFFFFFFF, 255);
        1:  set_cfg(0, 0, 0, 32'hFFFFFFFF, 2);
        2:  set_cfg(-32768, 32767, 1, 32'd2000, 0);
        3:  set_cfg(1000, 50, 65535, 32'hFFFFFFFF, 1);
        4:  set_cfg(-500, 20, 12345, 32'd3000, 255);
        default:
          set_cfg($signed(16'($urandom)) / 4, $urandom_range(0, 600), $urandom,
                  ($urandom_range(0, 2) == 0) ? $urandom_range(200, 3000) : $urandom,
                  $urandom_range(1, 6));
      endcase
      left = 170;
      while (left > 0) begin
        int n;
        n = $urandom_range(5, 60);
        gen_run(n, (ph == 2) ? 200 : 40);
        left -= n;
      end
    end
    wait_idle();
    repeat (20) @(posedge clk);
    $display("covered %0d inputs, %0d results: %0d with gains, %0d failed, %0d timed out",
             n_acc, n_res, n_gains, n_fail, n_tmo);
    if (errors == 0) begin
      $display("relay_autotune_pid_gains_core_tb: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("relay_autotune_pid_gains_core_tb: errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/ratpg_pkg.sv
rtl/ratpg_if.sv
rtl/relay_autotune_pid_gains_core.sv
tb/sv/relay_autotune_pid_gains_core_tb.sv
